// File: hw/rtl/u8d_pkg.sv
// Package for the UTF-8 byte stream decoder.
// Holds the shared field widths, item types, lead byte patterns and the lead classifier.
// No dependencies.
`timescale 1ns / 1ps

package u8d_pkg;

  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned CpWidth      = 21;
  localparam int unsigned PendingWidth = 2;
  localparam int unsigned ContBits     = 6;

  typedef logic [ByteWidth-1:0]    byte_t;
  typedef logic [CpWidth-1:0]      cp_t;
  typedef logic [PendingWidth-1:0] pending_t;

  // One input item as it leaves the input register.
  typedef struct packed {
    byte_t data;
    logic  last;
  } in_item_t;

  // One result item.
  typedef struct packed {
    cp_t  code_point;
    logic end_of_text;
  } out_item_t;

  // Lead byte masks, patterns and payload masks.
  localparam byte_t AsciiMask   = 8'h80;
  localparam byte_t Lead2Mask   = 8'hE0;
  localparam byte_t Lead2Pat    = 8'hC0;
  localparam byte_t Lead3Mask   = 8'hF0;
  localparam byte_t Lead3Pat    = 8'hE0;
  localparam byte_t Lead4Mask   = 8'hF8;
  localparam byte_t Lead4Pat    = 8'hF0;
  localparam byte_t Lead2Data   = 8'h1F;
  localparam byte_t Lead3Data   = 8'h0F;
  localparam byte_t Lead4Data   = 8'h07;
  localparam byte_t ContMask    = 8'hC0;
  localparam byte_t ContPat     = 8'h80;
  localparam byte_t ContData    = 8'h3F;

  localparam pending_t Pending2 = 2'd1;
  localparam pending_t Pending3 = 2'd2;
  localparam pending_t Pending4 = 2'd3;

  typedef enum logic [2:0] {
    LeadAscii,
    Lead2,
    Lead3,
    Lead4,
    LeadBad
  } lead_e;

  function automatic lead_e classify_lead(input byte_t b);
    lead_e cls;
    if ((b & AsciiMask) == 8'h00) begin
      cls = LeadAscii;
    end else if ((b & Lead2Mask) == Lead2Pat) begin
      cls = Lead2;
    end else if ((b & Lead3Mask) == Lead3Pat) begin
      cls = Lead3;
    end else if ((b & Lead4Mask) == Lead4Pat) begin
      cls = Lead4;
    end else begin
      cls = LeadBad;
    end
    return cls;
  endfunction

endpackage

// File: hw/rtl/u8d_in_stage.sv
// Input register stage of the UTF-8 byte stream decoder.
// Depends on u8d_pkg for the byte and item types.
`timescale 1ns / 1ps

module u8d_in_stage import u8d_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  byte_t    byte_in_i,
  input  logic     last_byte_i,
  output logic     item_valid_o,
  input  logic     item_take_i,
  output in_item_t item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;

  // The register frees up in the same cycle that the core takes its item.
  assign in_ready_o = !valid_q || item_take_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !item_take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.data <= byte_in_i;
      item_q.last <= last_byte_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// File: hw/rtl/u8d_core.sv
// Decode core of the UTF-8 byte stream decoder: sequence state, decode step and result register.
// Depends on u8d_pkg for types, lead patterns and the lead classifier.
`timescale 1ns / 1ps

module u8d_core import u8d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      item_valid_i,
  output logic      item_take_o,
  input  in_item_t  item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  pending_t  pending_q, pending_d;
  cp_t       acc_q, acc_d;
  logic      still_valid_q, still_valid_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  logic      emit;
  cp_t       emit_cp;
  lead_e     lead;
  pending_t  pending_dec;
  cp_t       acc_step;

  // A step runs whenever an item waits and the result register is free or being emptied.
  assign item_take_o = item_valid_i && (!out_valid_q || out_ready_i);

  assign lead        = classify_lead(item_i.data);
  assign pending_dec = pending_q - 2'd1;
  assign acc_step    = {acc_q[CpWidth-ContBits-1:0], item_i.data[ContBits-1:0] & ContData[ContBits-1:0]};

  always_comb begin
    pending_d     = pending_q;
    acc_d         = acc_q;
    still_valid_d = still_valid_q;
    emit          = 1'b0;
    emit_cp       = acc_q;

    if (pending_q == '0) begin
      case (lead)
        LeadAscii: begin
          emit    = 1'b1;
          emit_cp = cp_t'(item_i.data);
        end
        Lead2: begin
          acc_d         = cp_t'(item_i.data & Lead2Data);
          pending_d     = Pending2;
          still_valid_d = 1'b1;
        end
        Lead3: begin
          acc_d         = cp_t'(item_i.data & Lead3Data);
          pending_d     = Pending3;
          still_valid_d = 1'b1;
        end
        Lead4: begin
          acc_d         = cp_t'(item_i.data & Lead4Data);
          pending_d     = Pending4;
          still_valid_d = 1'b1;
        end
        default: begin
          // An invalid lead byte is dropped without a result.
        end
      endcase
      // A string that ends on a lead byte emits just the lead payload.
      if (item_i.last && lead != LeadBad && lead != LeadAscii) begin
        emit    = 1'b1;
        emit_cp = acc_d;
      end
    end else begin
      if (still_valid_q && ((item_i.data & ContMask) == ContPat)) begin
        acc_d = acc_step;
      end else begin
        still_valid_d = 1'b0;
      end
      pending_d = pending_dec;
      if (pending_dec == '0 || item_i.last) begin
        emit    = 1'b1;
        emit_cp = acc_d;
      end
    end

    // Every result and every last byte returns the sequence state to its reset values.
    if (emit || item_i.last) begin
      pending_d     = '0;
      acc_d         = '0;
      still_valid_d = 1'b1;
    end
  end

  assign out_valid_d = (item_take_o && emit) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q     <= '0;
      acc_q         <= '0;
      still_valid_q <= 1'b1;
      out_valid_q   <= 1'b0;
    end else begin
      if (item_take_o) begin
        pending_q     <= pending_d;
        acc_q         <= acc_d;
        still_valid_q <= still_valid_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o && emit) begin
      out_q.code_point  <= emit_cp;
      out_q.end_of_text <= item_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: hw/rtl/utf8_byte_stream_decoder.sv
// A byte goes from the input register through the decode step into the result register.
// Throughput: one byte per cycle unless a result stalls, set by the single decode step.
// A byte is transferred while an earlier result still waits; only a full pipe stalls the input.
// Reset (rst_ni low, asynchronous) empties both registers and clears the open sequence.
// Top level of the UTF-8 byte stream decoder; depends on u8d_pkg, u8d_in_stage and u8d_core.
`timescale 1ns / 1ps

module utf8_byte_stream_decoder import u8d_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  byte_t byte_in_i,
  input  logic  last_byte_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output cp_t   code_point_o,
  output logic  end_of_text_o
);

  logic      item_valid;
  logic      item_take;
  in_item_t  item;
  out_item_t out_item;

  u8d_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_in_i    (byte_in_i),
    .last_byte_i  (last_byte_i),
    .item_valid_o (item_valid),
    .item_take_i  (item_take),
    .item_o       (item)
  );

  u8d_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_take_o  (item_take),
    .item_i       (item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item)
  );

  assign code_point_o  = out_item.code_point;
  assign end_of_text_o = out_item.end_of_text;

endmodule

// File: hw/rtl/u8d_checker.sv
// Port-level checker for the UTF-8 byte stream decoder, bound to the top level.
// Depends on u8d_pkg for the field types.
`timescale 1ns / 1ps

module u8d_checker import u8d_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_ready_o,
  input byte_t byte_in_i,
  input logic  last_byte_i,
  input logic  out_valid_o,
  input logic  out_ready_i,
  input cp_t   code_point_o,
  input logic  end_of_text_o
);

  // The input only stalls when both stages hold data and the result is not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while the result register could drain");

  // A transfer into a stalled pipe fills it, so the input then follows the output ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && out_valid_o && !out_ready_i) |=> (!in_ready_o || out_ready_i))
    else $error("pipe accepted more bytes than it can hold");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped before its transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(code_point_o) && $stable(end_of_text_o)))
    else $error("result changed while stalled");

  // A waiting input byte stays offered with the same payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=>
      (in_valid_i && $stable(byte_in_i) && $stable(last_byte_i)))
    else $error("input byte withdrawn or changed before its transfer");

endmodule

bind utf8_byte_stream_decoder u8d_checker u_u8d_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .byte_in_i     (byte_in_i),
  .last_byte_i   (last_byte_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .code_point_o  (code_point_o),
  .end_of_text_o (end_of_text_o)
);
